>>> sv/oaat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaat_pkg
// Shared types, constants and mixing functions of the one-at-a-time hash.
// ----------------------------------------------------------------------------
package oaat_pkg;

  localparam int unsigned HASH_W = 32;
  localparam int unsigned BYTE_W = 8;

  localparam logic [HASH_W-1:0] SEED_VALUE = 32'd111119;
  localparam logic [BYTE_W-1:0] UPPER_LO   = 8'h41;
  localparam logic [BYTE_W-1:0] UPPER_HI   = 8'h5A;
  localparam logic [BYTE_W-1:0] CASE_DELTA = 8'h20;

  localparam int unsigned ABSORB_SHL = 10;
  localparam int unsigned ABSORB_SHR = 6;
  localparam int unsigned FINISH_SHL_A = 3;
  localparam int unsigned FINISH_SHR = 11;
  localparam int unsigned FINISH_SHL_B = 15;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              present;
    logic              last;
  } oaat_item_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic case_sensitive);
    if (!case_sensitive && (b inside {[UPPER_LO:UPPER_HI]})) begin
      return b + CASE_DELTA;
    end
    return b;
  endfunction

  function automatic logic [HASH_W-1:0] absorb(input logic [HASH_W-1:0] h,
                                               input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] t;
    t = h + {{(HASH_W-BYTE_W){1'b0}}, b};
    t = t + (t << ABSORB_SHL);
    t = t ^ (t >> ABSORB_SHR);
    return t;
  endfunction

  function automatic logic [HASH_W-1:0] finish(input logic [HASH_W-1:0] h);
    logic [HASH_W-1:0] t;
    t = h + (h << FINISH_SHL_A);
    t = t ^ (t >> FINISH_SHR);
    t = t + (t << FINISH_SHL_B);
    return t;
  endfunction

endpackage

>>> sv/oaat_input_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaat_input_stage
// Case setting register and input register; folds the byte on capture.
// ----------------------------------------------------------------------------
module oaat_input_stage
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_data,
  input  logic              in_take,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              byte_present,
  input  logic              last_byte,
  input  logic              advance,
  output logic              item_valid,
  output oaat_item_t        item
);

  logic case_sensitive;

  always_ff @(posedge clk) begin
    if (rst) begin
      case_sensitive <= 1'b0;
    end else if (cfg_valid) begin
      case_sensitive <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item.data    <= fold_byte(data_byte, case_sensitive);
      item.present <= byte_present;
      item.last    <= last_byte;
    end
  end

endmodule

>>> sv/oaat_hash_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaat_hash_core
// Running hash register; absorbs the byte of each word that holds one and hands off key ends.
// ----------------------------------------------------------------------------
module oaat_hash_core
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  oaat_item_t        item,
  input  logic              down_ready,
  output logic              advance,
  output logic              mix_valid,
  output logic [HASH_W-1:0] mix_hash
);

  logic [HASH_W-1:0] running_hash;
  logic [HASH_W-1:0] running_hash_next;
  logic [HASH_W-1:0] absorbed;
  logic              slot_ready;

  assign slot_ready = !mix_valid || down_ready;
  assign advance    = item_valid && (!item.last || slot_ready);
  assign absorbed   = item.present ? absorb(running_hash, item.data) : running_hash;

  always_comb begin
    running_hash_next = running_hash;
    if (advance) begin
      running_hash_next = item.last ? SEED_VALUE : absorbed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= SEED_VALUE;
    end else begin
      running_hash <= running_hash_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mix_valid <= 1'b0;
    end else if (advance && item.last) begin
      mix_valid <= 1'b1;
    end else if (down_ready) begin
      mix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.last) begin
      mix_hash <= absorbed;
    end
  end

endmodule

>>> sv/oaat_finish_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaat_finish_stage
// Final shift/add/xor mix into the result register.
// ----------------------------------------------------------------------------
module oaat_finish_stage
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              mix_valid,
  input  logic [HASH_W-1:0] mix_hash,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] hash_value
);

  assign ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= mix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && mix_valid) begin
      hash_value <= finish(mix_hash);
    end
  end

endmodule

>>> sv/string_hash_one_at_a_time.sv
`timescale 1ns / 1ps
// A word marked last passes the input register, mix_hash and hash_value before its hash shows on out_valid.
// Throughput: one word per cycle while in_stall is low; the running hash absorbs at most one byte per cycle.
// in_stall rises only when a finished hash is held by out_stall and a key end waits.
// Reset (rst, synchronous): pipeline empty, running hash at seed 111119, folding on.
// ----------------------------------------------------------------------------
// string_hash_one_at_a_time
// Streaming 32-bit one-at-a-time hash of byte keys with optional case folding.
// ----------------------------------------------------------------------------
module string_hash_one_at_a_time
  import oaat_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              byte_present,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HASH_W-1:0] hash_value
);

  logic              item_valid;
  oaat_item_t        item;
  logic              advance;
  logic              mix_valid;
  logic [HASH_W-1:0] mix_hash;
  logic              fin_ready;
  logic              in_take;

  assign cfg_ready = 1'b1;
  assign in_stall  = item_valid && !advance;
  assign in_take   = in_valid && !in_stall;

  oaat_input_stage u_input (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_take      (in_take),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  oaat_hash_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .down_ready (fin_ready),
    .advance    (advance),
    .mix_valid  (mix_valid),
    .mix_hash   (mix_hash)
  );

  oaat_finish_stage u_finish (
    .clk        (clk),
    .rst        (rst),
    .mix_valid  (mix_valid),
    .mix_hash   (mix_hash),
    .ready      (fin_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule

>>> sv/oaat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaat_checker
// Port-level checks of the hash block, bound to the top level.
// ----------------------------------------------------------------------------
module oaat_checker
  import oaat_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              cfg_ready,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [HASH_W-1:0] hash_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hash_value))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_cfg_open: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind string_hash_one_at_a_time oaat_checker u_oaat_checker (
  .clk        (clk),
  .rst        (rst),
  .cfg_ready  (cfg_ready),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .hash_value (hash_value)
);

>>> tb/string_hash_one_at_a_time_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_hash_one_at_a_time_tb
// Self-checking bench for the streaming one-at-a-time key hash. A scoreboard
// class tracks the running hash and case setting, predicts the finalized hash
// of every key end, and checks each delivered hash in order. Stimulus covers
// directed edge bytes and empty keys, then random keys under four idling
// mixes, register changes between phases, and a long output hold-off.
// ----------------------------------------------------------------------------
module string_hash_one_at_a_time_tb;
  import oaat_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned SETTLE_CYC   = 10;
  localparam int unsigned HOLD_CYC     = 400;
  localparam int unsigned PHASE_WORDS  = 455;
  localparam int unsigned REPORT_LIMIT = 10;

  class hash_scoreboard;
    logic [HASH_W-1:0] running;
    bit                case_sensitive;
    logic [HASH_W-1:0] expected_hashes[$];
    int unsigned       mismatches;
    int unsigned       hashes_seen;
    int unsigned       words_noted;

    function new();
      running        = SEED_VALUE;
      case_sensitive = 1'b0;
      mismatches     = 0;
      hashes_seen    = 0;
      words_noted    = 0;
    endfunction

    function void set_case(bit v);
      case_sensitive = v;
    endfunction

    function void note_word(oaat_item_t w);
      logic [BYTE_W-1:0] b;
      logic [HASH_W-1:0] h;
      words_noted++;
      if (w.present) begin
        b = w.data;
        if (!case_sensitive && b >= UPPER_LO && b <= UPPER_HI) begin
          b = b + CASE_DELTA;
        end
        h = running + {{(HASH_W-BYTE_W){1'b0}}, b};
        h = h + (h << ABSORB_SHL);
        h = h ^ (h >> ABSORB_SHR);
        running = h;
      end
      if (w.last) begin
        h = running;
        h = h + (h << FINISH_SHL_A);
        h = h ^ (h >> FINISH_SHR);
        h = h + (h << FINISH_SHL_B);
        expected_hashes.push_back(h);
        running = SEED_VALUE;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("MISMATCH: %s", msg);
      end
    endfunction

    function void check_hash(logic [HASH_W-1:0] got);
      logic [HASH_W-1:0] want;
      hashes_seen++;
      if (expected_hashes.size() == 0) begin
        report($sformatf("unexpected hash_value %08h", got));
        return;
      end
      want = expected_hashes.pop_front();
      if (got !== want) begin
        report($sformatf("hash_value expected %08h actual %08h", want, got));
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction

    function void wrap_up();
      while (expected_hashes.size() > 0) begin
        report($sformatf("hash %08h never arrived", expected_hashes.pop_front()));
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_present;
  logic              last_byte;
  logic              out_valid;
  logic              out_stall;
  logic [HASH_W-1:0] hash_value;

  hash_scoreboard sb = new();

  int unsigned cycle_count    = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned words_sent     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned hold_left      = 0;
  bit          hold_req       = 1'b0;

  string_hash_one_at_a_time uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hash_value   (hash_value)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (!rst && out_valid && !out_stall) begin
      sb.check_hash(hash_value);
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d hashes pending", cycle_count, sb.pending());
      $display("** string_hash_one_at_a_time: FAILED **");
      $finish;
    end
  end

  // Receiver: long hold-off on request, else random stall.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Called at a falling edge; returns at a falling edge with in_valid high.
  task automatic send_word(logic [BYTE_W-1:0] d, logic p, logic l);
    int unsigned gap;
    oaat_item_t  w;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    data_byte    <= d;
    byte_present <= p;
    last_byte    <= l;
    do @(posedge clk); while (in_stall);
    w.data    = d;
    w.present = p;
    w.last    = l;
    sb.note_word(w);
    if (p || l) words_sent++;
    @(negedge clk);
  endtask

  // Lower valid, wait for every hash, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_case(bit v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_case(v);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [BYTE_W-1:0] pick_byte();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return BYTE_W'(UPPER_LO + $urandom_range(25));
    if (r < 55) return BYTE_W'(8'h61 + $urandom_range(25));
    if (r < 62) return BYTE_W'(UPPER_LO - 1 + $urandom_range(1) * 27);
    return BYTE_W'($urandom_range(255));
  endfunction

  task automatic send_key(int unsigned max_len);
    int unsigned len;
    bit          end_on_byte;
    len         = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(max_len);
    end_on_byte = (len > 0) && $urandom_range(1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) begin
        send_word(BYTE_W'($urandom_range(255)), 1'b0, 1'b0);
      end
      if ($urandom_range(24) == 0) begin
        send_word(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
      send_word(pick_byte(), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte) begin
      send_word(BYTE_W'($urandom_range(255)), 1'b0, 1'b1);
    end
  endtask

  task automatic random_phase(int unsigned s_pct, int unsigned r_pct, int unsigned count);
    int unsigned stop_at;
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    stop_at        = words_sent + count;
    while (words_sent < stop_at) send_key(8);
  endtask

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = 1'b0;
    in_valid     = 1'b0;
    data_byte    = '0;
    byte_present = 1'b0;
    last_byte    = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty key, idle word, folding boundaries, zero and high bytes.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'hFF, 1'b0, 1'b0);
    send_word(8'h41, 1'b1, 1'b0);
    send_word(8'h5A, 1'b1, 1'b0);
    send_word(8'h40, 1'b1, 1'b0);
    send_word(8'h5B, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'h80, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'h7A, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    write_case(1'b1);
    send_word(8'h41, 1'b1, 1'b0);
    send_word(8'h5A, 1'b1, 1'b1);
    send_word(8'h00, 1'b0, 1'b1);
    // Change the setting in the middle of a key.
    send_word(8'h48, 1'b1, 1'b0);
    send_word(8'h69, 1'b1, 1'b0);
    write_case(1'b0);
    send_word(8'h49, 1'b1, 1'b0);
    send_word(8'h4A, 1'b1, 1'b1);

    random_phase(0, 0, PHASE_WORDS);
    write_case(1'b1);
    random_phase(66, 0, PHASE_WORDS);
    write_case(1'b0);
    random_phase(0, 66, PHASE_WORDS);
    write_case(1'b1);
    random_phase(21, 21, PHASE_WORDS);
    write_case(1'b0);

    // Hold the output while keys keep coming so the input backs up.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b1;
    for (int unsigned k = 0; k < 60; k++) send_key(2);

    drain();
    sb.wrap_up();
    $display("Run covered %0d words and %0d hashes, %0d register writes,",
             words_sent, sb.hashes_seen, cfg_writes);
    $display("four idling mixes and a %0d-cycle output hold-off.", HOLD_CYC);
    if (sb.mismatches == 0) begin
      $display("** string_hash_one_at_a_time: PASSED **");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("** string_hash_one_at_a_time: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
sv/oaat_pkg.sv
sv/oaat_input_stage.sv
sv/oaat_hash_core.sv
sv/oaat_finish_stage.sv
sv/string_hash_one_at_a_time.sv
sv/oaat_checker.sv
tb/string_hash_one_at_a_time_tb.sv
